>>> rtl/bump_and_first_fit_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and rst in scope at each use.
`ifndef BUMP_AND_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BUMP_AND_FIRST_FIT_ALLOCATOR_MACROS_SVH

// expr holds at every clock edge outside reset
`define FAA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// post holds in the cycle after pre
`define FAA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/faa_pkg.sv
// Shared types and constants of the bump and first-fit allocator.
// No dependencies.
`default_nettype none

package faa_pkg;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 32;
  localparam int FRAMES_W = 21;
  localparam int LEFT_W   = 33;
  localparam int NEED_W   = 33;

  localparam int DEF_FREE_DEPTH       = 64;
  localparam int DEF_FRAME_BYTES      = 4096;
  localparam int DEF_ARENA_MIN_FRAMES = 1024;

  localparam logic [FRAMES_W-1:0] FRAMES_CAP = 21'd1048576;
  localparam logic [LEFT_W-1:0]   LEFT_MAX   = {LEFT_W{1'b1}};
  localparam logic [NEED_W-1:0]   HDR_BYTES  = 33'd16;
  localparam logic [NEED_W-1:0]   ALIGN_ADD  = 33'd15;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ARENA = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_ARENA    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NULLFREE = 3'd4
  } status_t;

  typedef struct packed {
    logic              tok;
    logic              found;
    logic [ADDR_W-1:0] addr;
  } wave_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic push;
    logic inject;
    logic compact;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/bump_and_first_fit_allocator.sv
// Allocator front end: a free table searched newest-first in a row of cells,
// backed by a bump arena. Each transaction gives exactly one result. A free,
// an arena install, a zero-size or unknown request goes from S_DECIDE through
// S_HOLD to the result register, and the next transaction is accepted once the
// block is back in S_IDLE. An allocate first runs the search wave over each table
// entry held (up to FREE_DEPTH), stepping one cell per cycle, then closes the gap
// of a reused entry in S_COMPACT or takes a bump in S_BUMP. When the arena is
// short, the frame count is worked out in S_GROW by repeated doubling from
// ARENA_MIN_FRAMES. One transaction is in work at a time; the next one is
// accepted while the previous result still waits in the output register, and
// a finished result waits for as long as that register stays stalled.
// Depends on faa_pkg, faa_chain, faa_cell and the assertion macros.
`default_nettype none
`include "bump_and_first_fit_allocator_macros.svh"

module bump_and_first_fit_allocator #(
  parameter int FREE_DEPTH       = faa_pkg::DEF_FREE_DEPTH,
  parameter int FRAME_BYTES      = faa_pkg::DEF_FRAME_BYTES,
  parameter int ARENA_MIN_FRAMES = faa_pkg::DEF_ARENA_MIN_FRAMES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [faa_pkg::SIZE_W-1:0]      request_size,
  input  logic [faa_pkg::ADDR_W-1:0]      block_address,
  input  logic [faa_pkg::SIZE_W-1:0]      block_payload_size,
  input  logic [faa_pkg::FRAMES_W-1:0]    install_frames,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [faa_pkg::ADDR_W-1:0]      result_address,
  output logic [faa_pkg::FRAMES_W-1:0]    frames_wanted
);
  import faa_pkg::*;

  localparam int CNTW = $clog2(FREE_DEPTH + 1);
  localparam int FBW  = $clog2(FRAME_BYTES + 1);
  localparam int PW   = FRAMES_W + FBW;
  localparam int MW   = (PW > LEFT_W) ? PW : LEFT_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECIDE  = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_COMPACT = 7'b0001000,
    S_BUMP    = 7'b0010000,
    S_GROW    = 7'b0100000,
    S_HOLD    = 7'b1000000
  } state_t;

  state_t                state;
  action_t               act_q;
  logic [NEED_W-1:0]     need_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [SIZE_W-1:0]     psize_q;
  logic [FRAMES_W-1:0]   frames_q;
  logic [CNTW-1:0]       count;
  logic [ADDR_W-1:0]     bump_ptr;
  logic [LEFT_W-1:0]     bump_left;
  logic [FRAMES_W-1:0]   grow_frames;

  status_t               res_status;
  logic [ADDR_W-1:0]     res_addr;
  logic [FRAMES_W-1:0]   res_frames;
  status_t               out_status;
  logic [ADDR_W-1:0]     out_addr;
  logic [FRAMES_W-1:0]   out_frames;

  logic [NEED_W-1:0]     need_next;
  logic [NEED_W-1:0]     total;
  logic [PW-1:0]         inst_bytes;
  logic [LEFT_W-1:0]     inst_left;
  logic [PW-1:0]         grow_bytes;
  logic                  grow_short;
  logic [FRAMES_W:0]     grow_dbl;
  logic [FRAMES_W-1:0]   grow_frames_next;
  cell_ctl_t             ctl;
  entry_t                push_entry;
  wave_t                 wave_end;

  assign need_next  = ({1'b0, request_size} + ALIGN_ADD) & ~ALIGN_ADD;
  assign total      = need_q + HDR_BYTES;
  assign inst_bytes = PW'(frames_q) * PW'(FRAME_BYTES);
  assign inst_left  = (MW'(inst_bytes) > MW'(LEFT_MAX)) ? LEFT_MAX : LEFT_W'(inst_bytes);
  assign grow_bytes = PW'(grow_frames) * PW'(FRAME_BYTES);
  assign grow_short = (MW'(grow_bytes) < MW'(total));
  assign grow_dbl   = {grow_frames, 1'b0};
  assign grow_frames_next = (grow_dbl > {1'b0, FRAMES_CAP}) ? FRAMES_CAP
                                                            : grow_dbl[FRAMES_W-1:0];

  assign ctl.push    = (state == S_DECIDE) && (act_q == ACT_FREE) && (addr_q != '0) &&
                       (count != CNTW'(FREE_DEPTH));
  assign ctl.inject  = (state == S_DECIDE) && (act_q == ACT_ALLOC) && (need_q != '0) &&
                       (count != '0);
  assign ctl.compact = (state == S_COMPACT);
  assign push_entry.addr = addr_q;
  assign push_entry.size = psize_q;

  faa_chain #(.FREE_DEPTH(FREE_DEPTH)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .count      (count),
    .need       (need_q),
    .push_entry (push_entry),
    .wave_out   (wave_end)
  );

  assign in_stall       = (state != S_IDLE);
  assign status         = out_status;
  assign result_address = out_addr;
  assign frames_wanted  = out_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      bump_ptr  <= '0;
      bump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q    <= action_t'(action);
            need_q   <= need_next;
            addr_q   <= block_address;
            psize_q  <= block_payload_size;
            frames_q <= install_frames;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_addr   <= '0;
          res_frames <= '0;
          case (act_q)
            ACT_ALLOC: begin
              if (need_q == '0) begin
                res_status <= ST_ZERO;
                state      <= S_HOLD;
              end else if (count == '0) begin
                res_status <= ST_OK;
                state      <= S_BUMP;
              end else begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
            end
            ACT_FREE: begin
              state <= S_HOLD;
              if (addr_q == '0) begin
                res_status <= ST_NULLFREE;
              end else if (count == CNTW'(FREE_DEPTH)) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                count      <= count + 1'b1;
              end
            end
            ACT_ARENA: begin
              res_status <= ST_OK;
              state      <= S_HOLD;
              bump_ptr   <= addr_q;
              bump_left  <= inst_left;
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_HOLD;
            end
          endcase
        end
        S_SCAN: begin
          if (wave_end.tok) begin
            if (wave_end.found) begin
              res_addr <= wave_end.addr;
              state    <= S_COMPACT;
            end else begin
              state <= S_BUMP;
            end
          end
        end
        S_COMPACT: begin
          count <= count - 1'b1;
          state <= S_HOLD;
        end
        S_BUMP: begin
          if (bump_left >= total) begin
            res_addr  <= bump_ptr + ADDR_W'(HDR_BYTES);
            bump_ptr  <= bump_ptr + ADDR_W'(total);
            bump_left <= bump_left - total;
            state     <= S_HOLD;
          end else begin
            grow_frames <= FRAMES_W'(ARENA_MIN_FRAMES);
            state       <= S_GROW;
          end
        end
        S_GROW: begin
          if ((grow_frames < FRAMES_CAP) && grow_short) begin
            grow_frames <= grow_frames_next;
          end else begin
            res_status <= ST_ARENA;
            res_frames <= grow_frames;
            state      <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_addr   <= res_addr;
            out_frames <= res_frames;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FAA_ASSERT_ALWAYS(a_count_max, count <= CNTW'(FREE_DEPTH), "free table count past depth")
  `FAA_ASSERT_ALWAYS(a_scan_nonempty, (state != S_SCAN) || (count != '0), "empty table search")
  `FAA_ASSERT_NEXT(a_compact_drop, state == S_COMPACT, count == $past(count) - 1'b1, "reuse kept entry")

endmodule

`default_nettype wire

>>> rtl/faa_cell.sv
// One free-table cell: a stored entry and one stage of the search wave.
// Depends on faa_pkg.
`default_nettype none

module faa_cell #(
  parameter int FREE_DEPTH = faa_pkg::DEF_FREE_DEPTH,
  parameter int IDX        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  faa_pkg::cell_ctl_t                   ctl,
  input  logic [$clog2(FREE_DEPTH+1)-1:0]      count,
  input  logic [faa_pkg::NEED_W-1:0]           need,
  input  faa_pkg::entry_t                      push_entry,
  input  faa_pkg::wave_t                       wave_in,
  input  faa_pkg::entry_t                      entry_in,
  output faa_pkg::wave_t                       wave_out,
  output faa_pkg::entry_t                      entry_out
);
  import faa_pkg::*;

  localparam int CNTW = $clog2(FREE_DEPTH + 1);

  entry_t entry;
  wave_t  wave;
  logic   passed;
  logic   hit;
  logic   inject_here;
  logic   push_here;

  assign hit         = ({1'b0, entry.size} >= need);
  assign inject_here = ctl.inject && (count == CNTW'(IDX + 1));
  assign push_here   = ctl.push && (count == CNTW'(IDX));

  assign wave_out.tok   = wave.tok;
  assign wave_out.found = wave.found | (wave.tok & hit);
  assign wave_out.addr  = wave.found ? wave.addr : entry.addr;
  assign entry_out      = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave.tok <= 1'b0;
      passed   <= 1'b0;
    end else begin
      wave.tok <= inject_here | wave_in.tok;
      if (ctl.inject) begin
        passed <= 1'b0;
      end else if (wave.tok && !wave.found) begin
        passed <= 1'b1;
      end
    end
    wave.found <= inject_here ? 1'b0 : wave_in.found;
    wave.addr  <= wave_in.addr;
    if (push_here) begin
      entry <= push_entry;
    end else if (ctl.compact && passed) begin
      entry <= entry_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/faa_chain.sv
// Row of free-table cells; the search wave runs from the newest entry to cell 0.
// Depends on faa_pkg, faa_cell and the assertion macros.
`default_nettype none
`include "bump_and_first_fit_allocator_macros.svh"

module faa_chain #(
  parameter int FREE_DEPTH = faa_pkg::DEF_FREE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  faa_pkg::cell_ctl_t                   ctl,
  input  logic [$clog2(FREE_DEPTH+1)-1:0]      count,
  input  logic [faa_pkg::NEED_W-1:0]           need,
  input  faa_pkg::entry_t                      push_entry,
  output faa_pkg::wave_t                       wave_out
);
  import faa_pkg::*;

  wave_t                  wave_link  [FREE_DEPTH+1];
  entry_t                 entry_link [FREE_DEPTH+1];
  logic [FREE_DEPTH-1:0]  tok_vec;

  assign wave_link[FREE_DEPTH]  = '0;
  assign entry_link[FREE_DEPTH] = '0;
  assign wave_out               = wave_link[0];

  for (genvar j = 0; j < FREE_DEPTH; j++) begin : g_cell
    assign tok_vec[j] = wave_link[j].tok;
    faa_cell #(.FREE_DEPTH(FREE_DEPTH), .IDX(j)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .count      (count),
      .need       (need),
      .push_entry (push_entry),
      .wave_in    (wave_link[j+1]),
      .entry_in   (entry_link[j+1]),
      .wave_out   (wave_link[j]),
      .entry_out  (entry_link[j])
    );
  end

  `FAA_ASSERT_ALWAYS(a_single_wave, $onehot0(tok_vec), "more than one search wave in the row")

endmodule

`default_nettype wire
